@@ design/trrc_pkg.sv @@
// ----------------------------------------------------------------------------
// trrc_pkg
// Constants and widths shared by the three-term recurrence checksum.
// ----------------------------------------------------------------------------
package trrc_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned POS_W   = 8;

  // Offset added to the first byte of a message
  localparam logic [8:0]  FIRST_OFFSET = 9'd7;
  // Position multipliers, taken modulo 256
  localparam logic [7:0]  ALPHA_MULT   = 8'd17;
  localparam logic [7:0]  BETA_MULT    = 8'd31;
  // Checksum modulus
  localparam logic [16:0] MODULUS      = 17'd65535;
  // Multiple of the modulus that lifts any product difference above zero
  localparam logic [26:0] DIFF_BIAS    = 27'd16776960;

endpackage

@@ design/three_term_recurrence_checksum_top.sv @@
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum_top
// Running checksum over a byte stream, one result per byte, using a
// three-term recurrence reduced modulo 65535.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock and returns one checksum per
// byte, through the input register, then the result register. Sustained
// rate is one byte per cycle while m_axis_tready does not hold the result
// register: the recurrence, two small multiplies against the stored terms,
// the difference and the modulo 65535 fold, is combinational between the
// two registers, so each byte sees the terms left by the byte before it.
// tlast on the input closes the message; the matching result carries tlast
// and the terms return to their reset values for the next message.
module three_term_recurrence_checksum_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] checksum
  output logic        m_axis_tlast    // is_final
);

  // Input stage
  logic                          in_valid;
  logic [trrc_pkg::DATA_W-1:0]   in_byte;
  logic                          in_last;

  // Recurrence state
  logic [trrc_pkg::SUM_W-1:0]    older_term;
  logic [trrc_pkg::SUM_W-1:0]    newer_term;
  logic [trrc_pkg::POS_W-1:0]    byte_position;
  logic                          in_message;

  // Result stage
  logic                          out_valid;
  logic [trrc_pkg::SUM_W-1:0]    out_sum;
  logic                          out_last;

  logic                          out_free;
  logic                          advance;

  logic [7:0]                    alpha;
  logic [7:0]                    beta;
  logic [8:0]                    coef;
  logic [24:0]                   prod_new;
  logic [23:0]                   prod_old;
  logic [26:0]                   diff;
  logic                          diff_neg;
  logic [25:0]                   lifted;
  logic [16:0]                   fold1;
  logic [16:0]                   fold2;
  logic [15:0]                   rec_sum;
  logic [8:0]                    first_sum;
  logic [trrc_pkg::SUM_W-1:0]    result;

  // Handshake: result register drains, input register refills behind it
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sum;
  assign m_axis_tlast  = out_last;

  // Recurrence for a byte after the first, and the sum for the first byte
  always_comb begin
    alpha    = 8'(byte_position * trrc_pkg::ALPHA_MULT);
    beta     = 8'(byte_position * trrc_pkg::BETA_MULT);
    coef     = {1'b0, in_byte} + {1'b0, alpha};
    prod_new = 25'(coef) * 25'(newer_term);
    prod_old = 24'(beta) * 24'(older_term);
    diff     = {2'b00, prod_new} - {3'b000, prod_old};
    diff_neg = diff[26];
    // A negative difference wraps as 2^64, which is 1 modulo 65535
    lifted   = 26'(diff + 27'(diff_neg) + trrc_pkg::DIFF_BIAS);
    // Fold 2^16 = 1 modulo 65535, twice, then one conditional subtract
    fold1    = 17'(lifted[25:16]) + 17'(lifted[15:0]);
    fold2    = 17'(fold1[16]) + 17'(fold1[15:0]);
    if (fold2 >= trrc_pkg::MODULUS) begin
      rec_sum = 16'(fold2 - trrc_pkg::MODULUS);
    end else begin
      rec_sum = fold2[15:0];
    end
    first_sum = {1'b0, in_byte} + trrc_pkg::FIRST_OFFSET;
    result    = in_message ? rec_sum : 16'(first_sum);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Recurrence state: shift terms on each byte, reset at end of message
  always_ff @(posedge clk) begin
    if (rst) begin
      older_term    <= 16'd1;
      newer_term    <= 16'd1;
      byte_position <= '0;
      in_message    <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        older_term    <= 16'd1;
        newer_term    <= 16'd1;
        byte_position <= '0;
        in_message    <= 1'b0;
      end else if (!in_message) begin
        older_term    <= 16'd1;
        newer_term    <= result;
        byte_position <= 8'd1;
        in_message    <= 1'b1;
      end else begin
        older_term    <= newer_term;
        newer_term    <= result;
        byte_position <= byte_position + 8'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_sum  <= result;
      out_last <= in_last;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the three-term recurrence checksum against a cycle-free predictor.
// Directed messages cover single-byte messages, byte extremes and negative
// product differences. Random messages of mixed length follow, one long
// enough to wrap the byte position. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned          DATA_W       = trrc_pkg::DATA_W;
  localparam int unsigned          SUM_W        = trrc_pkg::SUM_W;
  localparam int unsigned          START_OFFSET = 7;
  localparam longint unsigned      STEP_ALPHA   = 17;
  localparam longint unsigned      STEP_BETA    = 31;
  localparam longint unsigned      FOLD         = 65535;
  localparam int unsigned          STALL_LIMIT  = 4000;
  localparam int unsigned          DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [SUM_W-1:0] checksum;
    logic             is_final;
  } sum_item_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_tvalid      = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata       = '0;
  logic              s_tlast       = 1'b0;
  logic              m_tvalid;
  logic              m_tready      = 1'b0;
  logic [SUM_W-1:0]  m_tdata;
  logic              m_tlast;

  // Recurrence state of the predictor
  logic [SUM_W-1:0]  older_sum     = 16'd1;
  logic [SUM_W-1:0]  newer_sum     = 16'd1;
  logic [7:0]        next_index    = 8'd0;
  logic              msg_open      = 1'b0;

  sum_item_t         pending_sums[$];
  sum_item_t         oldest_sum;
  int unsigned       fail_count    = 0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       src_idle_pct  = 0;
  int unsigned       sink_stall_pct = 0;

  three_term_recurrence_checksum_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [7:0] data_byte
    .s_axis_tlast  (s_tlast),   // last_byte
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [15:0] checksum
    .m_axis_tlast  (m_tlast)    // is_final
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the recurrence by one byte and return the checksum it yields
  function automatic sum_item_t next_checksum(input logic [DATA_W-1:0] b, input logic fin);
    longint unsigned alpha;
    longint unsigned beta;
    longint unsigned diff;
    sum_item_t       r;
    if (!msg_open) begin
      r.checksum = 16'(b) + 16'(START_OFFSET);
      older_sum  = 16'd1;
      newer_sum  = r.checksum;
      next_index = 8'd1;
      msg_open   = 1'b1;
    end else begin
      alpha = (longint'(next_index) * STEP_ALPHA) & 64'hFF;
      beta  = (longint'(next_index) * STEP_BETA) & 64'hFF;
      // 64-bit unsigned wrap is intended when the difference goes negative
      diff  = (longint'(b) + alpha) * longint'(newer_sum) - beta * longint'(older_sum);
      r.checksum = 16'(diff % FOLD);
      older_sum  = newer_sum;
      newer_sum  = r.checksum;
      next_index = next_index + 8'd1;
    end
    r.is_final = fin;
    // Close the message: terms go back to their idle values
    if (fin) begin
      older_sum  = 16'd1;
      newer_sum  = 16'd1;
      next_index = 8'd0;
      msg_open   = 1'b0;
    end
    return r;
  endfunction

  // Send one byte, with random idle cycles ahead of it, and log its checksum
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_sums.push_back(next_checksum(b, fin));
  endtask

  // Hold the input side until every outstanding checksum has come back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(DATA_W'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Single-byte messages at both byte extremes and at 128
  task automatic test_single_byte_messages();
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b1);
    send_byte(8'd128, 1'b1);
  endtask

  // All-ones and alternating bytes push the products to their largest
  task automatic test_byte_extremes();
    for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
    for (int i = 0; i < 4; i++) send_byte((i % 2) ? 8'hAA : 8'h55, i == 3);
  endtask

  // A run of zero bytes turns the product difference negative by the sixth byte
  task automatic test_negative_difference();
    for (int i = 0; i < 9; i++) send_byte(8'd0, i == 8);
  endtask

  // One message longer than 256 bytes so the position wraps; hit zero at the wrap
  task automatic test_position_wrap();
    for (int i = 0; i < 300; i++) begin
      send_byte((i == 256) ? 8'd0 : DATA_W'($urandom_range(255)), i == 299);
    end
  endtask

  // Mostly short messages, some medium, a few up to 80 bytes
  task automatic test_random_messages(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic        paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(6, 1);
      else if (pick < 95) len = $urandom_range(30, 7);
      else                len = $urandom_range(80, 31);
      send_random_message(len);
      sent += len;
      if (!paused && sent >= n_bytes / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
  endtask

  // Drive the output ready and check every checksum transaction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_sums.size() == 0) begin
          $error("unexpected checksum transaction: checksum %0d is_final %0b",
                 m_tdata, m_tlast);
          fail_count++;
        end else begin
          oldest_sum = pending_sums.pop_front();
          if (m_tdata !== oldest_sum.checksum) begin
            $error("checksum mismatch: expected %0d, actual %0d",
                   oldest_sum.checksum, m_tdata);
            fail_count++;
          end
          if (m_tlast !== oldest_sum.is_final) begin
            $error("is_final mismatch: expected %0b, actual %0b",
                   oldest_sum.is_final, m_tlast);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stop the run if neither side moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct   = 22;
    sink_stall_pct = 47;
    test_single_byte_messages();
    test_byte_extremes();
    test_negative_difference();
    test_random_messages(350);

    src_idle_pct   = 47;
    sink_stall_pct = 22;
    test_random_messages(350);
    test_position_wrap();

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_messages(350);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
